/* sv/mcsw_pkg.sv */
// types, constants and trig functions shared by the motion cone search window
`timescale 1ns / 1ps

package mcsw_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int FRACTION_BITS = 4;
  localparam int SH            = FRACTION_BITS + 14;
  localparam int PW            = 32;
  localparam int EW            = ((13 + SH) > PW ? (13 + SH) : PW) + 2;
  localparam int NPH           = 3;
  localparam int NTR           = 2;
  localparam int NPR           = NPH * NTR;
  localparam int CFG_DW        = 15;
  localparam int CFG_AW        = 2;

  typedef logic [15:0]          phase_t;
  typedef logic signed [15:0]   trig_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [EW-1:0] edge_t;
  typedef logic [12:0]          pix_t;

  localparam pix_t   MAX_SIZE = 13'd4096;
  localparam phase_t QUARTER  = 16'h4000;

  typedef enum logic [CFG_AW-1:0] {
    REG_IMAGE_WIDTH     = 2'd0,
    REG_IMAGE_HEIGHT    = 2'd1,
    REG_MARGIN_PIXELS   = 2'd2,
    REG_CONE_HALF_ANGLE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [11:0] margin_pixels;
    logic [14:0] cone_half_angle;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [15:0]        heading;
    logic signed [15:0] near_travel;
    logic signed [15:0] far_travel;
  } item_t;

  typedef struct packed {
    logic [15:0]           pos_x;
    logic [15:0]           pos_y;
    logic [NTR-1:0][15:0]  trav;
    logic [NPH-1:0][15:0]  cos_v;
    logic [NPH-1:0][15:0]  sin_v;
  } trig_st_t;

  typedef struct packed {
    logic [15:0]           pos_x;
    logic [15:0]           pos_y;
    logic [NPR-1:0][PW-1:0] vx;
    logic [NPR-1:0][PW-1:0] vy;
  } proj_t;

  typedef struct packed {
    logic [EW-1:0] sx;
    logic [EW-1:0] sy;
    logic [EW-1:0] ex;
    logic [EW-1:0] ey;
  } box_t;

  typedef struct packed {
    pix_t start_x;
    pix_t start_y;
    pix_t end_x;
    pix_t end_y;
    pix_t span_x;
    pix_t span_y;
  } res_t;

  // quarter wave of sine, 16384 full scale
  localparam logic [14:0] QSINE [17] = '{
    15'd0,     15'd1606,  15'd3196,  15'd4756,  15'd6270,  15'd7723,
    15'd9102,  15'd10394, 15'd11585, 15'd12665, 15'd13623, 15'd14449,
    15'd15137, 15'd15679, 15'd16069, 15'd16305, 15'd16384
  };

  function automatic logic [14:0] quarter_wave(input logic [14:0] u);
    logic [4:0]  idx;
    logic [9:0]  fr;
    logic [14:0] lo;
    logic [14:0] hi;
    logic [10:0] dif;
    logic [20:0] prod;
    idx  = {1'b0, u[13:10]};
    fr   = u[9:0];
    lo   = QSINE[idx];
    hi   = QSINE[idx + 5'd1];
    dif  = 11'(hi - lo);
    prod = 21'(dif) * 21'(fr);
    return u[14] ? 15'd16384 : lo + 15'(prod[20:10]);
  endfunction

  function automatic trig_t sine16(input phase_t p);
    logic [14:0] u;
    logic [14:0] w;
    u = p[14] ? (15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
    w = quarter_wave(u);
    return p[15] ? -$signed({1'b0, w}) : $signed({1'b0, w});
  endfunction

  function automatic phase_t to_phase(input logic [ANGLE_BITS-1:0] a);
    logic [ANGLE_BITS+15:0] ext;
    ext = {a, 16'b0};
    return ext[ANGLE_BITS+15 -: 16];
  endfunction

endpackage

/* sv/motion_cone_search_window_top.sv */
// top level of the motion cone search window: config registers and stage chain
// five register stages, each with its own valid: input, trig, proj, box and clip
// throughput: one word per cycle while out_ready is high
// a stage reloads whenever it is empty or the next one takes its word
// reset (rst_n low, synchronous) empties all stages and loads the register defaults
`timescale 1ns / 1ps

module motion_cone_search_window_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mcsw_pkg::CFG_AW-1:0]         cfg_index,
  input  logic [mcsw_pkg::CFG_DW-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [15:0]                         in_pos_x,
  input  logic [15:0]                         in_pos_y,
  input  logic [15:0]                         in_heading,
  input  logic signed [15:0]                  in_near_travel,
  input  logic signed [15:0]                  in_far_travel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [12:0]                         out_start_x,
  output logic [12:0]                         out_start_y,
  output logic [12:0]                         out_end_x,
  output logic [12:0]                         out_end_y,
  output logic [12:0]                         out_span_x,
  output logic [12:0]                         out_span_y
);
  import mcsw_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     s0_vld_r;
  item_t    s0_r;
  logic     s1_rdy;
  logic     s1_vld;
  trig_st_t s1_data;
  logic     s2_rdy;
  logic     s2_vld;
  proj_t    s2_data;
  logic     s3_rdy;
  logic     s3_vld;
  box_t     s3_data;
  logic     s4_rdy;
  res_t     res;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_IMAGE_WIDTH:     cfg_nxt.image_width     = cfg_wdata[12:0];
        REG_IMAGE_HEIGHT:    cfg_nxt.image_height    = cfg_wdata[12:0];
        REG_MARGIN_PIXELS:   cfg_nxt.margin_pixels   = cfg_wdata[11:0];
        REG_CONE_HALF_ANGLE: cfg_nxt.cone_half_angle = cfg_wdata[14:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= 13'd640;
      cfg_r.image_height    <= 13'd480;
      cfg_r.margin_pixels   <= 12'd32;
      cfg_r.cone_half_angle <= 15'd4096;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input register
  assign in_ready = !s0_vld_r || s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_ready) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_r.pos_x       <= in_pos_x;
      s0_r.pos_y       <= in_pos_y;
      s0_r.heading     <= in_heading;
      s0_r.near_travel <= in_near_travel;
      s0_r.far_travel  <= in_far_travel;
    end
  end

  mcsw_trig u_trig (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (s0_vld_r),
    .up_ready (s1_rdy),
    .up_data  (s0_r),
    .dn_valid (s1_vld),
    .dn_ready (s2_rdy),
    .dn_data  (s1_data)
  );

  mcsw_proj u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_vld),
    .up_ready (s2_rdy),
    .up_data  (s1_data),
    .dn_valid (s2_vld),
    .dn_ready (s3_rdy),
    .dn_data  (s2_data)
  );

  mcsw_box u_box (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (s2_vld),
    .up_ready (s3_rdy),
    .up_data  (s2_data),
    .dn_valid (s3_vld),
    .dn_ready (s4_rdy),
    .dn_data  (s3_data)
  );

  mcsw_clip u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (s3_vld),
    .up_ready (s4_rdy),
    .up_data  (s3_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (res)
  );

  assign out_start_x = res.start_x;
  assign out_start_y = res.start_y;
  assign out_end_x   = res.end_x;
  assign out_end_y   = res.end_y;
  assign out_span_x  = res.span_x;
  assign out_span_y  = res.span_y;

endmodule

/* sv/mcsw_trig.sv */
// stage that forms the three cone phases and their sine and cosine
`timescale 1ns / 1ps

module mcsw_trig (
  input  logic              clk,
  input  logic              rst_n,
  input  mcsw_pkg::cfg_t    cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  mcsw_pkg::item_t   up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output mcsw_pkg::trig_st_t dn_data
);
  import mcsw_pkg::*;

  logic                  vld_r;
  trig_st_t              trig_r;
  trig_st_t              trig_nxt;
  logic [ANGLE_BITS-1:0] hd;
  logic [ANGLE_BITS-1:0] cn;
  phase_t                ph [NPH];

  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_data  = trig_r;

  always_comb begin
    hd    = ANGLE_BITS'(up_data.heading);
    cn    = ANGLE_BITS'(cfg.cone_half_angle);
    ph[0] = to_phase(hd);
    ph[1] = to_phase(hd + cn);
    ph[2] = to_phase(hd - cn);
    trig_nxt.pos_x   = up_data.pos_x;
    trig_nxt.pos_y   = up_data.pos_y;
    trig_nxt.trav[0] = up_data.far_travel;
    trig_nxt.trav[1] = up_data.near_travel;
    for (int i = 0; i < NPH; i++) begin
      trig_nxt.cos_v[i] = sine16(ph[i] + QUARTER);
      trig_nxt.sin_v[i] = sine16(ph[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      trig_r <= trig_nxt;
    end
  end

endmodule

/* sv/mcsw_proj.sv */
// stage that projects both travels onto the three cone directions
`timescale 1ns / 1ps

module mcsw_proj (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  mcsw_pkg::trig_st_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output mcsw_pkg::proj_t    dn_data
);
  import mcsw_pkg::*;

  logic  vld_r;
  proj_t proj_r;
  proj_t proj_nxt;
  prod_t mx;
  prod_t my;

  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_data  = proj_r;

  always_comb begin
    proj_nxt.pos_x = up_data.pos_x;
    proj_nxt.pos_y = up_data.pos_y;
    mx = '0;
    my = '0;
    for (int i = 0; i < NPH; i++) begin
      for (int j = 0; j < NTR; j++) begin
        mx = prod_t'($signed(up_data.trav[j])) * prod_t'($signed(up_data.cos_v[i]));
        my = prod_t'($signed(up_data.trav[j])) * prod_t'($signed(up_data.sin_v[i]));
        proj_nxt.vx[i*NTR+j] = mx;
        proj_nxt.vy[i*NTR+j] = my;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      proj_r <= proj_nxt;
    end
  end

endmodule

/* sv/mcsw_box.sv */
// stage that takes the bounding box, moves it by the position and pads it
`timescale 1ns / 1ps

module mcsw_box (
  input  logic            clk,
  input  logic            rst_n,
  input  mcsw_pkg::cfg_t  cfg,
  input  logic            up_valid,
  output logic            up_ready,
  input  mcsw_pkg::proj_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output mcsw_pkg::box_t  dn_data
);
  import mcsw_pkg::*;

  logic  vld_r;
  box_t  box_r;
  box_t  box_nxt;
  prod_t lo_x;
  prod_t hi_x;
  prod_t lo_y;
  prod_t hi_y;
  edge_t px;
  edge_t py;
  edge_t mg;

  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_data  = box_r;

  always_comb begin
    lo_x = '0;
    hi_x = '0;
    lo_y = '0;
    hi_y = '0;
    for (int k = 0; k < NPR; k++) begin
      if ($signed(up_data.vx[k]) < lo_x) lo_x = up_data.vx[k];
      if ($signed(up_data.vx[k]) > hi_x) hi_x = up_data.vx[k];
      if ($signed(up_data.vy[k]) < lo_y) lo_y = up_data.vy[k];
      if ($signed(up_data.vy[k]) > hi_y) hi_y = up_data.vy[k];
    end
    px = edge_t'({up_data.pos_x, 14'b0});
    py = edge_t'({up_data.pos_y, 14'b0});
    mg = edge_t'({cfg.margin_pixels, {SH{1'b0}}});
    box_nxt.sx = edge_t'(lo_x) + px - mg;
    box_nxt.sy = edge_t'(lo_y) + py - mg;
    box_nxt.ex = edge_t'(hi_x) + px + mg;
    box_nxt.ey = edge_t'(hi_y) + py + mg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      box_r <= box_nxt;
    end
  end

endmodule

/* sv/mcsw_clip.sv */
// stage that clamps the window to the image and forms the result word
`timescale 1ns / 1ps

module mcsw_clip (
  input  logic           clk,
  input  logic           rst_n,
  input  mcsw_pkg::cfg_t cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  mcsw_pkg::box_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output mcsw_pkg::res_t dn_data
);
  import mcsw_pkg::*;

  logic vld_r;
  res_t res_r;
  res_t res_nxt;
  pix_t sw;
  pix_t sh;
  edge_t lx;
  edge_t ly;

  function automatic pix_t to_pixel(input edge_t v, input edge_t lim);
    edge_t c;
    priority if (v < 0) begin
      c = '0;
    end else if (v > lim) begin
      c = lim;
    end else begin
      c = v;
    end
    return c[SH+12:SH];
  endfunction

  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_data  = res_r;

  always_comb begin
    sw = (cfg.image_width > MAX_SIZE) ? MAX_SIZE : cfg.image_width;
    sh = (cfg.image_height > MAX_SIZE) ? MAX_SIZE : cfg.image_height;
    lx = edge_t'({sw, {SH{1'b0}}});
    ly = edge_t'({sh, {SH{1'b0}}});
    res_nxt.start_x = to_pixel($signed(up_data.sx), lx);
    res_nxt.start_y = to_pixel($signed(up_data.sy), ly);
    res_nxt.end_x   = to_pixel($signed(up_data.ex), lx);
    res_nxt.end_y   = to_pixel($signed(up_data.ey), ly);
    res_nxt.span_x  = (res_nxt.end_x > res_nxt.start_x) ?
                      res_nxt.end_x - res_nxt.start_x : '0;
    res_nxt.span_y  = (res_nxt.end_y > res_nxt.start_y) ?
                      res_nxt.end_y - res_nxt.start_y : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r <= res_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !vld_r)
    else $error("result valid right after reset");

  a_span_x: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (res_r.span_x == ((res_r.end_x > res_r.start_x) ?
                                res_r.end_x - res_r.start_x : 13'd0)))
    else $error("x span does not match edges");

  a_end_x_lim: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (res_r.end_x <= sw && res_r.start_x <= sw))
    else $error("x edge beyond image width");

  a_end_y_lim: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (res_r.end_y <= sh && res_r.start_y <= sh))
    else $error("y edge beyond image height");

endmodule
